// ===== rtl/dli_pkg.sv =====
package dli_pkg;

  // default time stamp width
  localparam int TIME_BITS_DEFAULT = 32;

  // item kinds
  localparam logic KIND_POLL   = 1'b0;
  localparam logic KIND_EXPOSE = 1'b1;

  // busy modes of a poll word (code 3 behaves as light lock)
  localparam logic [1:0] BUSY_IDLE  = 2'd0;
  localparam logic [1:0] BUSY_TIMER = 2'd1;
  localparam logic [1:0] BUSY_LOCK  = 2'd2;

  // switch bit positions
  localparam int SW_FOCUS = 0;
  localparam int SW_SAFE  = 1;
  localparam int SW_ROOM  = 2;

  // levels and display mapping
  localparam logic [7:0] DEFAULT_SAFE  = 8'd30;
  localparam logic [7:0] DEFAULT_FOCUS = 8'd255;
  localparam logic [6:0] DIM_LOW       = 7'd10;
  localparam logic [6:0] DIM_SPAN      = 7'd90;

  // register reset values
  localparam logic [7:0]  SAFE_LEVEL_RST    = 8'd0;
  localparam logic [7:0]  FOCUS_LEVEL_RST   = 8'd0;
  localparam logic [7:0]  DISPLAY_LEVEL_RST = 8'd255;
  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd30;

  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    REG_SAFE_LEVEL    = 2'd0,
    REG_FOCUS_LEVEL   = 2'd1,
    REG_DISPLAY_LEVEL = 2'd2,
    REG_DEBOUNCE_MS   = 2'd3
  } cfg_reg_t;

  // light request status shared between control and color selection
  typedef struct packed {
    logic       focus;
    logic       safe;
    logic       exposure;
    logic       dark;
    logic [6:0] dim;
  } light_status_t;

  // floor(level * 90 / 255) + 10, the divide by 255 done by reciprocal
  function automatic logic [6:0] dim_of(input logic [7:0] level);
    logic [15:0] prod;
    logic [15:0] quo;
    begin
      prod = 16'(level) * 16'(DIM_SPAN);
      quo  = (prod + (prod >> 8) + 16'd1) >> 8;
      dim_of = quo[6:0] + DIM_LOW;
    end
  endfunction

endpackage

// ===== rtl/dli_item_if.sv =====
interface dli_item_if #(
  parameter int TIME_BITS = dli_pkg::TIME_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic                 focus_raw;
  logic                 safe_raw;
  logic                 room_raw;
  logic [TIME_BITS-1:0] now_ms;
  logic [1:0]           busy_mode;
  logic                 ui_safe_set;
  logic                 ui_white_set;
  logic                 ui_room_set;
  logic [7:0]           red;
  logic [7:0]           green;
  logic [7:0]           blue;

  modport source (
    output valid, kind, focus_raw, safe_raw, room_raw, now_ms, busy_mode,
           ui_safe_set, ui_white_set, ui_room_set, red, green, blue,
    input  ready
  );
  modport sink (
    input  valid, kind, focus_raw, safe_raw, room_raw, now_ms, busy_mode,
           ui_safe_set, ui_white_set, ui_room_set, red, green, blue,
    output ready
  );
endinterface

// ===== rtl/dli_result_if.sv =====
interface dli_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_red;
  logic [7:0] pixel_green;
  logic [7:0] pixel_blue;
  logic       safe_on;
  logic       enlarger_on;
  logic       room_dark;
  logic [6:0] display_dim;

  modport source (
    output valid, pixel_red, pixel_green, pixel_blue, safe_on, enlarger_on,
           room_dark, display_dim,
    input  ready
  );
  modport sink (
    input  valid, pixel_red, pixel_green, pixel_blue, safe_on, enlarger_on,
           room_dark, display_dim,
    output ready
  );
endinterface

// ===== rtl/darkroom_light_interlock_unit.sv =====
// Darkroom light interlock: takes one word per clock on item unless stalled
// and gives one result word for each, through an input register, then the
// result register behind the switch/latch update logic. Poll words debounce
// the focus, safelight and room switches against now_ms, merge the UI
// latches, trap a focus request that rises under safelight, and refresh the
// light requests on change, on the first full poll, or after a timer busy
// period. Exposure words set an RGB color; nonzero, it overrides the pixel.
// Pixel color follows exposure, safelight, focus, off. Write configuration
// through cfg_we/cfg_index/cfg_data only while no words are in flight.
module darkroom_light_interlock_unit #(
  parameter int TIME_BITS = dli_pkg::TIME_BITS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_index,
  input  logic [dli_pkg::CFG_DATA_BITS-1:0] cfg_data,
  dli_item_if.sink                          item,
  dli_result_if.source                      result
);

  // configuration registers
  logic [7:0]  safe_level;
  logic [7:0]  focus_level;
  logic [7:0]  display_level;
  logic [15:0] debounce_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      safe_level    <= dli_pkg::SAFE_LEVEL_RST;
      focus_level   <= dli_pkg::FOCUS_LEVEL_RST;
      display_level <= dli_pkg::DISPLAY_LEVEL_RST;
      debounce_ms   <= dli_pkg::DEBOUNCE_MS_RST;
    end else if (cfg_we) begin
      unique case (dli_pkg::cfg_reg_t'(cfg_index))
        dli_pkg::REG_SAFE_LEVEL:    safe_level    <= cfg_data[7:0];
        dli_pkg::REG_FOCUS_LEVEL:   focus_level   <= cfg_data[7:0];
        dli_pkg::REG_DISPLAY_LEVEL: display_level <= cfg_data[7:0];
        dli_pkg::REG_DEBOUNCE_MS:   debounce_ms   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic                 s1_valid;
  logic                 s1_kind;
  logic [2:0]           s1_raw;
  logic [TIME_BITS-1:0] s1_now;
  logic [1:0]           s1_busy;
  logic [2:0]           s1_ui;
  logic [23:0]          s1_color;

  // result stage moves when empty or when the word is taken
  logic advance;
  assign advance    = !result.valid || result.ready;
  assign item.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_kind  <= item.kind;
      s1_raw   <= {item.room_raw, item.safe_raw, item.focus_raw};
      s1_now   <= item.now_ms;
      s1_busy  <= item.busy_mode;
      s1_ui    <= {item.ui_room_set, item.ui_safe_set, item.ui_white_set};
      s1_color <= {item.red, item.green, item.blue};
    end
  end

  // state update fires when the word leaves the input register
  logic                   update;
  dli_pkg::light_status_t status_next;
  logic [23:0]            color_next;

  assign update = s1_valid && advance;

  dli_light_ctrl #(
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .update        (update),
    .kind          (s1_kind),
    .raw           (s1_raw),
    .now_ms        (s1_now),
    .busy_mode     (s1_busy),
    .ui_set        (s1_ui),
    .color_in      (s1_color),
    .display_level (display_level),
    .debounce_ms   (debounce_ms),
    .status_next   (status_next),
    .color_next    (color_next)
  );

  // color selection on the updated status
  logic [7:0] pix_red;
  logic [7:0] pix_green;
  logic [7:0] pix_blue;
  logic       safe_on;
  logic       enlarger_on;

  dli_color_mux u_color (
    .status      (status_next),
    .color       (color_next),
    .safe_level  (safe_level),
    .focus_level (focus_level),
    .red         (pix_red),
    .green       (pix_green),
    .blue        (pix_blue),
    .safe_on     (safe_on),
    .enlarger_on (enlarger_on)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      result.pixel_red   <= pix_red;
      result.pixel_green <= pix_green;
      result.pixel_blue  <= pix_blue;
      result.safe_on     <= safe_on;
      result.enlarger_on <= enlarger_on;
      result.room_dark   <= status_next.dark;
      result.display_dim <= status_next.dim;
    end
  end

  // an empty result stage never stalls the input side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !result.valid |-> item.ready)
    else $error("input stalled with empty result register");

endmodule

// ===== rtl/dli_light_ctrl.sv =====
module dli_light_ctrl #(
  parameter int TIME_BITS = dli_pkg::TIME_BITS_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    update,
  input  logic                    kind,
  input  logic [2:0]              raw,
  input  logic [TIME_BITS-1:0]    now_ms,
  input  logic [1:0]              busy_mode,
  input  logic [2:0]              ui_set,
  input  logic [23:0]             color_in,
  input  logic [7:0]              display_level,
  input  logic [15:0]             debounce_ms,
  output dli_pkg::light_status_t  status_next,
  output logic [23:0]             color_next
);

  logic [2:0]           raw_prev;
  logic [TIME_BITS-1:0] stamp [3];
  logic [2:0]           debounced;
  logic [2:0]           latches;
  logic                 trap;
  logic                 last_focus;
  logic [2:0]           last_sent;
  logic                 first_pending;
  logic                 busy_flag;
  dli_pkg::light_status_t status;
  logic [23:0]          color;

  logic [2:0]           raw_prev_next;
  logic [TIME_BITS-1:0] stamp_next [3];
  logic [TIME_BITS-1:0] age [3];
  logic [2:0]           debounced_next;
  logic [2:0]           latches_next;
  logic                 trap_next;
  logic                 last_focus_next;
  logic [2:0]           last_sent_next;
  logic                 first_pending_next;
  logic                 busy_flag_next;
  logic [2:0]           targets;
  logic [2:0]           changed;
  logic [2:0]           wanted;
  logic                 focus_want;

  always_comb begin
    raw_prev_next      = raw_prev;
    stamp_next         = stamp;
    age                = '{default: '0};
    debounced_next     = debounced;
    latches_next       = latches;
    trap_next          = trap;
    last_focus_next    = last_focus;
    last_sent_next     = last_sent;
    first_pending_next = first_pending;
    busy_flag_next     = busy_flag;
    status_next        = status;
    color_next         = color;
    targets            = '0;
    changed            = '0;
    wanted             = '0;
    focus_want         = 1'b0;

    if (kind == dli_pkg::KIND_EXPOSE) begin
      color_next           = color_in;
      status_next.exposure = |color_in;
    end else begin
      latches_next = latches | ui_set;
      case (busy_mode)
        dli_pkg::BUSY_IDLE: begin
          // per switch debounce against its last change time
          for (int i = 0; i < 3; i++) begin
            if (raw[i] != raw_prev[i]) begin
              stamp_next[i] = now_ms;
            end
            age[i] = now_ms - stamp_next[i];
            if (age[i] >= TIME_BITS'(debounce_ms)) begin
              debounced_next[i] = raw[i];
            end
          end
          raw_prev_next = raw;

          // physical off clears the latch
          latches_next = latches_next & debounced_next;
          wanted       = debounced_next | latches_next;
          focus_want   = wanted[dli_pkg::SW_FOCUS];

          // focus rising while safelight is wanted gets trapped
          if (focus_want && !last_focus && wanted[dli_pkg::SW_SAFE]) begin
            trap_next = 1'b1;
            latches_next[dli_pkg::SW_FOCUS] = 1'b0;
          end
          if (!focus_want) begin
            trap_next = 1'b0;
          end
          last_focus_next = focus_want;

          targets[dli_pkg::SW_FOCUS] = focus_want && !trap_next;
          targets[dli_pkg::SW_SAFE]  = debounced_next[dli_pkg::SW_SAFE] |
                                       latches_next[dli_pkg::SW_SAFE];
          targets[dli_pkg::SW_ROOM]  = debounced_next[dli_pkg::SW_ROOM] |
                                       latches_next[dli_pkg::SW_ROOM];

          changed = (first_pending || busy_flag) ? 3'b111 : (targets ^ last_sent);
          if (changed[dli_pkg::SW_FOCUS]) begin
            status_next.focus = targets[dli_pkg::SW_FOCUS];
          end
          if (changed[dli_pkg::SW_SAFE]) begin
            status_next.safe = targets[dli_pkg::SW_SAFE];
          end
          if (changed[dli_pkg::SW_ROOM]) begin
            status_next.dark = targets[dli_pkg::SW_ROOM];
            status_next.dim  = targets[dli_pkg::SW_ROOM] ? 7'd0 :
                               dli_pkg::dim_of(display_level);
          end
          last_sent_next     = targets;
          first_pending_next = 1'b0;
          busy_flag_next     = 1'b0;
        end
        dli_pkg::BUSY_TIMER: begin
          busy_flag_next = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev      <= '0;
      stamp         <= '{default: '0};
      debounced     <= '0;
      latches       <= '0;
      trap          <= 1'b0;
      last_focus    <= 1'b0;
      last_sent     <= '0;
      first_pending <= 1'b1;
      busy_flag     <= 1'b0;
      status        <= '0;
      color         <= '0;
    end else if (update) begin
      raw_prev      <= raw_prev_next;
      stamp         <= stamp_next;
      debounced     <= debounced_next;
      latches       <= latches_next;
      trap          <= trap_next;
      last_focus    <= last_focus_next;
      last_sent     <= last_sent_next;
      first_pending <= first_pending_next;
      busy_flag     <= busy_flag_next;
      status        <= status_next;
      color         <= color_next;
    end
  end

  a_dark_dim_zero: assert property (@(posedge clk) disable iff (rst)
    status.dark |-> status.dim == 7'd0)
    else $error("dark room with nonzero dimming");

  a_trap_needs_focus: assert property (@(posedge clk) disable iff (rst)
    trap |-> last_focus)
    else $error("trap lock held without focus request");

  a_exposure_color: assert property (@(posedge clk) disable iff (rst)
    status.exposure == (color != 24'd0))
    else $error("exposure flag does not match stored color");

  a_sync_clears: assert property (@(posedge clk) disable iff (rst)
    update && kind == dli_pkg::KIND_POLL && busy_mode == dli_pkg::BUSY_IDLE
    |=> !first_pending && !busy_flag)
    else $error("full poll left resync pending");

endmodule

// ===== rtl/dli_color_mux.sv =====
module dli_color_mux (
  input  dli_pkg::light_status_t status,
  input  logic [23:0]            color,
  input  logic [7:0]             safe_level,
  input  logic [7:0]             focus_level,
  output logic [7:0]             red,
  output logic [7:0]             green,
  output logic [7:0]             blue,
  output logic                   safe_on,
  output logic                   enlarger_on
);

  logic [7:0] safe_red;
  logic [7:0] focus_white;

  assign safe_red    = (safe_level != 8'd0) ? safe_level : dli_pkg::DEFAULT_SAFE;
  assign focus_white = (focus_level != 8'd0) ? focus_level : dli_pkg::DEFAULT_FOCUS;

  // priority: exposure, safelight, focus, off
  always_comb begin
    red   = 8'd0;
    green = 8'd0;
    blue  = 8'd0;
    if (status.exposure) begin
      red   = color[23:16];
      green = color[15:8];
      blue  = color[7:0];
    end else if (status.safe) begin
      red = safe_red;
    end else if (status.focus) begin
      red   = focus_white;
      green = focus_white;
      blue  = focus_white;
    end
  end

  assign safe_on     = status.safe;
  assign enlarger_on = status.exposure || (status.focus && !status.safe);

endmodule
